// ===== design/dwa_pkg.sv =====
// shared types, codes and constants of the dfa word acceptor
package dwa_pkg;

  // default sizes, handed to the top level parameters
  localparam int NUM_STATES_DEF  = 16;
  localparam int SYMBOL_BITS_DEF = 8;

  // fixed field widths
  localparam int KIND_W   = 3;
  localparam int STATE_W  = 4;
  localparam int SYM_W    = 8;
  localparam int REASON_W = 3;
  // wide enough to compare any field against a count up to 256
  localparam int CMP_W    = 9;

  // configuration port
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_START_STATE = 1'b0;
  localparam logic REG_START_VALID = 1'b1;

  // item kinds
  localparam logic [KIND_W-1:0] K_LOAD  = 3'd0;
  localparam logic [KIND_W-1:0] K_FINAL = 3'd1;
  localparam logic [KIND_W-1:0] K_ALPHA = 3'd2;
  localparam logic [KIND_W-1:0] K_CHAR  = 3'd3;
  localparam logic [KIND_W-1:0] K_END   = 3'd4;

  // word result reasons
  localparam logic [REASON_W-1:0] RSN_OK        = 3'd0;
  localparam logic [REASON_W-1:0] RSN_BAD_DFA   = 3'd1;
  localparam logic [REASON_W-1:0] RSN_ALPHABET  = 3'd2;
  localparam logic [REASON_W-1:0] RSN_NO_TRANS  = 3'd3;
  localparam logic [REASON_W-1:0] RSN_NOT_FINAL = 3'd4;

  // controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_CHAR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic sweep;     // clearing pass: write zero, advance sweep counter
    logic take;      // input transfer this cycle
    logic load_fin;  // table entry read back for a transition load
    logic char_fin;  // table entry read back for a word character
  } dwa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_done;
    logic need_load;
    logic need_char;
    logic is_end;
  } dwa_stat_t;

endpackage

// ===== design/dwa_ctrl.sv =====
// controller: clearing pass, item sequencing and output handshake
module dwa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dwa_pkg::dwa_stat_t stat,
  output dwa_pkg::dwa_cmd_t  cmd
);
  import dwa_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;
  logic   accept;

  // state and output slot registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // an item is taken when idle and the result slot can hold a new result
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && slot_free);
  assign accept    = in_valid && !in_stall;

  // result slot stays full while stalled, fills on an end of word
  assign out_valid_next = (out_valid && out_stall) || (accept && stat.is_end);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.take = accept;
        if (accept && stat.need_load) begin
          state_next = S_LOAD;
        end else if (accept && stat.need_char) begin
          state_next = S_CHAR;
        end
      end
      S_LOAD: begin
        cmd.load_fin = 1'b1;
        state_next   = S_IDLE;
      end
      S_CHAR: begin
        cmd.char_fin = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/dwa_datapath.sv =====
// datapath: tables, word state, configuration registers and result register
module dwa_datapath #(
  parameter int NUM_STATES  = dwa_pkg::NUM_STATES_DEF,
  parameter int SYMBOL_BITS = dwa_pkg::SYMBOL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dwa_pkg::dwa_cmd_t              cmd,
  output dwa_pkg::dwa_stat_t             stat,
  input  logic [dwa_pkg::KIND_W-1:0]     kind,
  input  logic [dwa_pkg::STATE_W-1:0]    from_state,
  input  logic [dwa_pkg::STATE_W-1:0]    to_state,
  input  logic [dwa_pkg::SYM_W-1:0]      symbol,
  input  logic                           is_epsilon,
  input  logic                           final_flag,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dwa_pkg::CFG_AW-1:0]     paddr,
  input  logic [dwa_pkg::CFG_DW-1:0]     pwdata,
  output logic [dwa_pkg::CFG_DW-1:0]     prdata,
  output logic                           accepted,
  output logic [dwa_pkg::REASON_W-1:0]   reason
);
  import dwa_pkg::*;

  localparam int SYM_COUNT = 1 << SYMBOL_BITS;
  localparam int ST_W      = $clog2(NUM_STATES);
  localparam int TBL_AW    = ST_W + SYMBOL_BITS;
  localparam int TBL_DEPTH = NUM_STATES * SYM_COUNT;
  localparam int ENTRY_W   = STATE_W + 1;

  // configuration and word state
  logic [STATE_W-1:0]    start_state;
  logic                  start_valid;
  logic [STATE_W-1:0]    cur_state;
  logic [REASON_W-1:0]   word_reason;
  logic                  nondet;
  logic [NUM_STATES-1:0] final_marks;
  logic [TBL_AW-1:0]     sweep_cnt;

  // item held across the memory read
  logic [TBL_AW-1:0]     lat_addr;
  logic [STATE_W-1:0]    lat_to;
  logic                  lat_sym_ok;

  // memories: table entry is {valid, next state}
  logic [ENTRY_W-1:0]    tbl_mem [TBL_DEPTH];
  logic                  alpha_mem [SYM_COUNT];
  logic [ENTRY_W-1:0]    entry_q;
  logic                  alpha_q;

  logic                  from_ok;
  logic                  to_ok;
  logic                  sym_ok;
  logic                  cur_ok;
  logic                  start_ok;
  logic [TBL_AW-1:0]     from_addr;
  logic [TBL_AW-1:0]     cur_addr;
  logic [TBL_AW-1:0]     rd_addr;
  logic                  tbl_we;
  logic [TBL_AW-1:0]     tbl_wa;
  logic [ENTRY_W-1:0]    tbl_wd;
  logic                  alpha_we;
  logic [SYMBOL_BITS-1:0] alpha_wa;
  logic                  cfg_wr;
  logic [REASON_W-1:0]   end_reason;

  // range checks
  assign from_ok  = CMP_W'(from_state) < CMP_W'(NUM_STATES);
  assign to_ok    = CMP_W'(to_state) < CMP_W'(NUM_STATES);
  assign sym_ok   = CMP_W'(symbol) < CMP_W'(SYM_COUNT);
  assign cur_ok   = CMP_W'(cur_state) < CMP_W'(NUM_STATES);
  assign start_ok = CMP_W'(start_state) < CMP_W'(NUM_STATES);

  // table addresses: state in the high bits, byte in the low bits
  assign from_addr = {ST_W'(from_state), symbol[SYMBOL_BITS-1:0]};
  assign cur_addr  = {ST_W'(cur_state), symbol[SYMBOL_BITS-1:0]};
  assign rd_addr   = (kind == K_CHAR) ? cur_addr : from_addr;

  // status for the controller
  assign stat.sweep_done = sweep_cnt == TBL_AW'(TBL_DEPTH - 1);
  assign stat.need_load  = (kind == K_LOAD) && !is_epsilon && from_ok && to_ok && sym_ok;
  assign stat.need_char  = (kind == K_CHAR) && (word_reason == RSN_OK);
  assign stat.is_end     = kind == K_END;

  // table write port: clearing pass or a new transition
  assign tbl_we = cmd.sweep || (cmd.load_fin && !entry_q[STATE_W]);
  assign tbl_wa = cmd.sweep ? sweep_cnt : lat_addr;
  assign tbl_wd = cmd.sweep ? ENTRY_W'(0) : {1'b1, lat_to};

  // alphabet write port: clearing pass or a new byte
  assign alpha_we = cmd.sweep || (cmd.take && (kind == K_ALPHA) && sym_ok);
  assign alpha_wa = cmd.sweep ? sweep_cnt[SYMBOL_BITS-1:0] : symbol[SYMBOL_BITS-1:0];

  // transition table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    entry_q <= tbl_mem[rd_addr];
  end

  // alphabet memory
  always_ff @(posedge clk) begin
    if (alpha_we) begin
      alpha_mem[alpha_wa] <= !cmd.sweep;
    end
    alpha_q <= alpha_mem[symbol[SYMBOL_BITS-1:0]];
  end

  // reason reported at the end of a word
  always_comb begin
    if (!start_valid || !start_ok || nondet) begin
      end_reason = RSN_BAD_DFA;
    end else if (word_reason != RSN_OK) begin
      end_reason = word_reason;
    end else if (!(cur_ok && final_marks[ST_W'(cur_state)])) begin
      end_reason = RSN_NOT_FINAL;
    end else begin
      end_reason = RSN_OK;
    end
  end

  assign cfg_wr = psel && penable && pwrite;

  // control state: configuration, word progress, flags, final marks
  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
      start_valid <= 1'b0;
      cur_state   <= '0;
      word_reason <= RSN_OK;
      nondet      <= 1'b0;
      final_marks <= '0;
      sweep_cnt   <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + TBL_AW'(1);
      end
      if (cmd.take) begin
        case (kind)
          K_LOAD: begin
            if (is_epsilon) begin
              nondet <= 1'b1;
            end
          end
          K_FINAL: begin
            if (from_ok) begin
              final_marks[ST_W'(from_state)] <= final_flag;
            end
          end
          K_END: begin
            cur_state   <= start_state;
            word_reason <= RSN_OK;
          end
          default: begin
          end
        endcase
      end
      // a second transition for the same state and byte
      if (cmd.load_fin && entry_q[STATE_W]) begin
        nondet <= 1'b1;
      end
      // step the word, first failure wins
      if (cmd.char_fin) begin
        if (!lat_sym_ok || !alpha_q) begin
          word_reason <= RSN_ALPHABET;
        end else if (!cur_ok || !entry_q[STATE_W]) begin
          word_reason <= RSN_NO_TRANS;
        end else begin
          cur_state <= entry_q[STATE_W-1:0];
        end
      end
      // register writes
      if (cfg_wr) begin
        unique case (paddr[REG_SEL_BIT])
          REG_START_STATE: begin
            start_state <= pwdata[STATE_W-1:0];
            cur_state   <= pwdata[STATE_W-1:0];
          end
          REG_START_VALID: begin
            start_valid <= pwdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // item fields held across the table read, and the result register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lat_addr   <= from_addr;
      lat_to     <= to_state;
      lat_sym_ok <= sym_ok;
      if (kind == K_END) begin
        accepted <= end_reason == RSN_OK;
        reason   <= end_reason;
      end
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_START_STATE: prdata = CFG_DW'(start_state);
      REG_START_VALID: prdata = CFG_DW'(start_valid);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== design/dfa_word_acceptor_core.sv =====
// top level of the dfa word acceptor: controller plus datapath
//
// Loads a deterministic automaton item by item (transitions, final marks,
// alphabet bytes), then runs words through it one character per item and
// gives one result, accepted and reason, at each end of word. After reset a
// clearing pass sweeps the transition and alphabet memories, one entry per
// cycle; no item is taken during it, register writes are. A transition load
// that can write the table (not an epsilon move, all fields in range) and a
// character of a word that has not failed yet also pass through the load or
// char state, because the transition table is a memory with a registered
// read that must come back before the entry can be checked or followed;
// every other item is finished from idle. A finished result waits in an
// output register while the next items are taken; while that result is held
// by a stalled receiver, no item of any kind is taken. Registers sit at
// byte address 0 (start state, also moves the current state) and 4 (start
// valid), written by the user only while idle; not enforced by the core.
module dfa_word_acceptor_core #(
  parameter int NUM_STATES  = dwa_pkg::NUM_STATES_DEF,
  parameter int SYMBOL_BITS = dwa_pkg::SYMBOL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dwa_pkg::KIND_W-1:0]   kind,
  input  logic [dwa_pkg::STATE_W-1:0]  from_state,
  input  logic [dwa_pkg::STATE_W-1:0]  to_state,
  input  logic [dwa_pkg::SYM_W-1:0]    symbol,
  input  logic                         is_epsilon,
  input  logic                         final_flag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         accepted,
  output logic [dwa_pkg::REASON_W-1:0] reason,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dwa_pkg::CFG_AW-1:0]   paddr,
  input  logic [dwa_pkg::CFG_DW-1:0]   pwdata,
  output logic [dwa_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import dwa_pkg::*;

  dwa_cmd_t  cmd;
  dwa_stat_t stat;

  // no wait states on the register port
  assign pready = 1'b1;

  // sequencing and handshakes
  dwa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tables, word state and registers
  dwa_datapath #(
    .NUM_STATES  (NUM_STATES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .from_state (from_state),
    .to_state   (to_state),
    .symbol     (symbol),
    .is_epsilon (is_epsilon),
    .final_flag (final_flag),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .accepted   (accepted),
    .reason     (reason)
  );

endmodule
